[sv/dda_line_rasterizer_top_defines.svh]
// Assertion macros for the DDA line rasterizer.
`ifndef DDA_LINE_RASTERIZER_TOP_DEFINES_SVH
`define DDA_LINE_RASTERIZER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DLR_CHECK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DLR_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/dlr_pkg.sv]
// Shared types and constants of the DDA line rasterizer.
`timescale 1ns / 1ps
`default_nettype none
package dlr_pkg;

  // Fraction bits of the per-point increment ratio.
  localparam int RATIO_BITS = 16;
  // Ratio span/step lies in [0, 1], so one extra integer bit.
  localparam int QUOT_W = RATIO_BITS + 1;
  // Frame size registers.
  localparam int REG_W = 7;
  localparam logic [REG_W-1:0] FRAME_RESET = 7'd64;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SETUP = 5'b00010,
    ST_DIVX  = 5'b00100,
    ST_DIVY  = 5'b01000,
    ST_EMIT  = 5'b10000
  } seq_state_t;

  // Controls from the sequencer to the point walker.
  typedef struct packed {
    logic load;
    logic advance;
  } walk_ctl_t;

endpackage
`default_nettype wire

[sv/dlr_div.sv]
// Serial restoring divider: (num << RATIO_BITS) / den, with num <= den.
`timescale 1ns / 1ps
`default_nettype none
module dlr_div #(
  parameter int COORD_W = 14
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [COORD_W-1:0]          num,
  input  wire logic [COORD_W-1:0]          den,
  output logic                             done,
  output logic [dlr_pkg::QUOT_W-1:0]       quot
);

  localparam int CNT_W = $clog2(dlr_pkg::QUOT_W + 1);

  logic [COORD_W:0]   rem;
  logic [COORD_W:0]   diff;
  logic [COORD_W-1:0] rem_keep;
  logic               ge;
  logic [CNT_W-1:0]   cnt;
  logic               busy;

  // One quotient bit per cycle; the remainder always stays below den.
  always_comb begin
    ge       = rem >= {1'b0, den};
    diff     = rem - {1'b0, den};
    rem_keep = ge ? diff[COORD_W-1:0] : rem[COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(dlr_pkg::QUOT_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {1'b0, num};
    end else if (busy) begin
      rem  <= {rem_keep, 1'b0};
      quot <= {quot[dlr_pkg::QUOT_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

[sv/dlr_walk.sv]
// Point walker: fixed-point position accumulators, point counter and clip test.
`timescale 1ns / 1ps
`default_nettype none
module dlr_walk #(
  parameter int COORD_W       = 14,
  parameter int PIX_W         = 6,
  parameter int FRACTION_BITS = 8
) (
  input  wire logic                          clk,
  input  wire dlr_pkg::walk_ctl_t            ctl,
  input  wire logic [COORD_W-1:0]            start_x,
  input  wire logic [COORD_W-1:0]            start_y,
  input  wire logic [dlr_pkg::QUOT_W-1:0]    inc_x,
  input  wire logic [dlr_pkg::QUOT_W-1:0]    inc_y,
  input  wire logic                          neg_x,
  input  wire logic                          neg_y,
  input  wire logic [PIX_W-1:0]              left_init,
  input  wire logic [dlr_pkg::REG_W-1:0]     frame_width,
  input  wire logic [dlr_pkg::REG_W-1:0]     frame_height,
  output logic [PIX_W-1:0]                   pixel_x,
  output logic [PIX_W-1:0]                   pixel_y,
  output logic                               write_enable,
  output logic                               last_point
);

  localparam int POS_W = COORD_W + dlr_pkg::RATIO_BITS;

  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;
  logic [POS_W-1:0] step_x;
  logic [POS_W-1:0] step_y;
  logic [PIX_W-1:0] left;

  // The ratio is truncated toward zero, so positions stay between the endpoints.
  assign step_x = POS_W'(inc_x) << FRACTION_BITS;
  assign step_y = POS_W'(inc_y) << FRACTION_BITS;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pos_x <= POS_W'(start_x) << dlr_pkg::RATIO_BITS;
      pos_y <= POS_W'(start_y) << dlr_pkg::RATIO_BITS;
      left  <= left_init;
    end else if (ctl.advance) begin
      pos_x <= neg_x ? pos_x - step_x : pos_x + step_x;
      pos_y <= neg_y ? pos_y - step_y : pos_y + step_y;
      left  <= left - PIX_W'(1);
    end
  end

  assign pixel_x      = pos_x[POS_W-1 -: PIX_W];
  assign pixel_y      = pos_y[POS_W-1 -: PIX_W];
  assign write_enable = (dlr_pkg::REG_W'(pixel_x) < frame_width) &&
                        (dlr_pkg::REG_W'(pixel_y) < frame_height);
  assign last_point   = (left == '0);

endmodule
`default_nettype wire

[sv/dda_line_rasterizer_top.sv]
// Top level of the DDA line rasterizer: sequencer, frame registers, divider and walker.
`timescale 1ns / 1ps
`default_nettype none
//
// Usage:
//   Slave stream (s_*): one beat is one line command. s_tdata, from bit 0 up:
//   start_x, start_y, end_x, end_y (unsigned fixed point), line_color.
//   Master stream (m_*): one beat per point. m_tdata holds pixel_x, pixel_y,
//   pixel_color; m_tuser is write_enable (point inside the frame); m_tlast
//   marks the final point of the line.
//   Config channel (cfg_*): index 0 writes frame_width, index 1 frame_height.
//   It is always ready; write it only while no line is in progress.
// Timing:
//   A command is taken only while the block is idle. After a setup state,
//   the shared serial divider forms the x and then the y ratio, one quotient
//   bit a cycle (17 bits each); equal endpoints skip the division. Points
//   then follow, one point a cycle while m_tready is high, up to FRAME_SIZE
//   points.
// Reset: frame registers go to 64 by 64, the sequencer returns to idle and
//   any line in progress is dropped.
// Stall: with m_tready low the current point holds on m_* until taken.
//
module dda_line_rasterizer_top #(
  parameter int FRAME_SIZE    = 64,
  parameter int FRACTION_BITS = 8,
  localparam int PIX_W    = $clog2(FRAME_SIZE),
  localparam int COORD_W  = PIX_W + FRACTION_BITS,
  localparam int IN_W     = 4 * COORD_W + 32,
  localparam int IN_DW    = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W    = 2 * PIX_W + 32,
  localparam int OUT_DW   = ((OUT_W + 7) / 8) * 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // start_x, start_y, end_x, end_y, line_color (zero padded)
  input  wire logic [IN_DW-1:0]                   s_tdata,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // pixel_x, pixel_y, pixel_color (zero padded)
  output logic [OUT_DW-1:0]                       m_tdata,
  // write_enable
  output logic                                    m_tuser,
  output logic                                    m_tlast,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [dlr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [dlr_pkg::REG_W-1:0]          cfg_data
);

  dlr_pkg::seq_state_t state;

  logic [dlr_pkg::REG_W-1:0] frame_width;
  logic [dlr_pkg::REG_W-1:0] frame_height;

  // Latched command
  logic [COORD_W-1:0] x0, y0, x1, y1;
  logic [31:0]        color;

  // Setup results
  logic [COORD_W-1:0] adx, ady, step;
  logic [COORD_W-1:0] adx_next, ady_next, step_next;
  logic               neg_x, neg_y;
  logic [PIX_W-1:0]   left_next;
  logic [PIX_W-1:0]   step_hi;

  // Divider
  logic                       div_start;
  logic                       div_done;
  logic [COORD_W-1:0]         div_num;
  logic [dlr_pkg::QUOT_W-1:0] div_quot;
  logic [dlr_pkg::QUOT_W-1:0] inc_x, inc_y;

  // Walker
  dlr_pkg::walk_ctl_t walk_ctl;
  logic [PIX_W-1:0]   pixel_x, pixel_y;
  logic               write_enable, last_point;

  logic in_beat, out_beat;

  assign s_tready  = (state == dlr_pkg::ST_IDLE);
  assign in_beat   = s_tvalid && s_tready;
  assign m_tvalid  = (state == dlr_pkg::ST_EMIT);
  assign out_beat  = m_tvalid && m_tready;
  assign cfg_ready = 1'b1;

  // Frame registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= dlr_pkg::FRAME_RESET;
      frame_height <= dlr_pkg::FRAME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (dlr_pkg::cfg_reg_t'(cfg_index))
        dlr_pkg::CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
        dlr_pkg::CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Spans, step and point count
  always_comb begin
    adx_next  = (x0 >= x1) ? x0 - x1 : x1 - x0;
    ady_next  = (y0 >= y1) ? y0 - y1 : y1 - y0;
    step_next = (adx_next >= ady_next) ? adx_next : ady_next;
    step_hi   = step_next[COORD_W-1:FRACTION_BITS];
    // Saturate at FRAME_SIZE points
    left_next = (step_hi > PIX_W'(FRAME_SIZE - 1)) ? PIX_W'(FRAME_SIZE - 1) : step_hi;
  end

  // Latch the command beat
  always_ff @(posedge clk) begin
    if (in_beat) begin
      x0    <= s_tdata[COORD_W-1:0];
      y0    <= s_tdata[2*COORD_W-1:COORD_W];
      x1    <= s_tdata[3*COORD_W-1:2*COORD_W];
      y1    <= s_tdata[4*COORD_W-1:3*COORD_W];
      color <= s_tdata[IN_W-1:4*COORD_W];
    end
    if (state == dlr_pkg::ST_SETUP) begin
      adx   <= adx_next;
      ady   <= ady_next;
      step  <= step_next;
      neg_x <= x1 < x0;
      neg_y <= y1 < y0;
    end
    // Equal endpoints: no division, zero increments
    if (state == dlr_pkg::ST_SETUP && step_next == '0) begin
      inc_x <= '0;
      inc_y <= '0;
    end else if (state == dlr_pkg::ST_DIVX && div_done) begin
      inc_x <= div_quot;
    end else if (state == dlr_pkg::ST_DIVY && div_done) begin
      inc_y <= div_quot;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dlr_pkg::ST_IDLE;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      unique case (state)
        dlr_pkg::ST_IDLE: begin
          if (in_beat) state <= dlr_pkg::ST_SETUP;
        end
        dlr_pkg::ST_SETUP: begin
          if (step_next == '0) begin
            state <= dlr_pkg::ST_EMIT;
          end else begin
            state     <= dlr_pkg::ST_DIVX;
            div_start <= 1'b1;
          end
        end
        dlr_pkg::ST_DIVX: begin
          if (div_done) begin
            state     <= dlr_pkg::ST_DIVY;
            div_start <= 1'b1;
          end
        end
        dlr_pkg::ST_DIVY: begin
          if (div_done) state <= dlr_pkg::ST_EMIT;
        end
        dlr_pkg::ST_EMIT: begin
          if (out_beat && last_point) state <= dlr_pkg::ST_IDLE;
        end
        default: state <= dlr_pkg::ST_IDLE;
      endcase
    end
  end

  // Shared divider: x span first, then y span
  assign div_num = (state == dlr_pkg::ST_DIVY) ? ady : adx;

  dlr_div #(
    .COORD_W (COORD_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (step),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Walker loads at setup and advances on every accepted point but the last
  always_comb begin
    walk_ctl.load    = (state == dlr_pkg::ST_SETUP);
    walk_ctl.advance = out_beat && !last_point;
  end

  dlr_walk #(
    .COORD_W       (COORD_W),
    .PIX_W         (PIX_W),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_walk (
    .clk          (clk),
    .ctl          (walk_ctl),
    .start_x      (x0),
    .start_y      (y0),
    .inc_x        (inc_x),
    .inc_y        (inc_y),
    .neg_x        (neg_x),
    .neg_y        (neg_y),
    .left_init    (left_next),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .write_enable (write_enable),
    .last_point   (last_point)
  );

  assign m_tdata = OUT_DW'({color, pixel_y, pixel_x});
  assign m_tuser = write_enable;
  assign m_tlast = last_point;

`include "dda_line_rasterizer_top_defines.svh"

  `DLR_CHECK_NOW(a_no_overlap, s_tready, !m_tvalid, "point beat while idle")
  `DLR_CHECK_NEXT(a_cmd_busy, in_beat, !s_tready, "ready right after a command beat")
  `DLR_CHECK_NEXT(a_last_idle, out_beat && m_tlast, s_tready, "not idle after last point")
  `DLR_CHECK_NOW(a_div_quiet, m_tvalid, !div_start && !div_done, "divider active while emitting")

endmodule
`default_nettype wire

[tb/dda_line_rasterizer_top_tb.sv]
// Self-checking testbench for the DDA line rasterizer top level.
`timescale 1ns / 1ps

module dda_line_rasterizer_top_tb;

  localparam int FRAME_SIZE    = 64;
  localparam int FRACTION_BITS = 8;
  localparam int PIX_W   = $clog2(FRAME_SIZE);
  localparam int COORD_W = PIX_W + FRACTION_BITS;
  localparam int IN_W    = 4 * COORD_W + 32;
  localparam int IN_DW   = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W   = 2 * PIX_W + 32;
  localparam int OUT_DW  = ((OUT_W + 7) / 8) * 8;

  // Cycles to let pass after the last point before touching the registers.
  localparam int DRAIN_CYCLES = 80;
  // Long receiver hold-off that backs the block up into its input.
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int NUM_PHASES   = 6;
  localparam int PHASE_LINES  = 41;

  typedef enum logic [0:0] {
    ROW_LINE,
    ROW_CFG
  } row_kind_e;

  // One row of the directed table; random lines reuse the same shape.
  typedef struct packed {
    row_kind_e                     kind;
    logic [COORD_W-1:0]            sx;
    logic [COORD_W-1:0]            sy;
    logic [COORD_W-1:0]            ex;
    logic [COORD_W-1:0]            ey;
    logic [31:0]                   color;
    logic                          typed;   // expected point typed in below
    logic [PIX_W-1:0]              px;
    logic [PIX_W-1:0]              py;
    logic                          we;
    logic [dlr_pkg::REG_W-1:0]     w;
    logic [dlr_pkg::REG_W-1:0]     h;
  } stim_row_t;

  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    logic [31:0]      color;
    logic             we;
    logic             last;
  } pixel_t;

  logic                           clk = 1'b0;
  logic                           rst;
  logic [IN_DW-1:0]               s_tdata;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [OUT_DW-1:0]              m_tdata;
  logic                           m_tuser;
  logic                           m_tlast;
  logic                           m_tvalid;
  logic                           m_tready;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [dlr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [dlr_pkg::REG_W-1:0]      cfg_data;

  pixel_t                    expected_points[$];
  logic [dlr_pkg::REG_W-1:0] frame_w_model;
  logic [dlr_pkg::REG_W-1:0] frame_h_model;
  stim_row_t                 directed[$];
  int unsigned               mismatch_count = 0;
  int unsigned               cycle_count = 0;
  bit                        tx_quiet = 1'b0;
  bit                        rx_quiet = 1'b0;
  bit                        rx_hold_req = 1'b0;

  dda_line_rasterizer_top #(
    .FRAME_SIZE    (FRAME_SIZE),
    .FRACTION_BITS (FRACTION_BITS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Give up on a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d points pending",
               cycle_count, expected_points.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Signed increment ratio span/step with RATIO_BITS fraction bits, truncated.
  function automatic longint span_ratio(input longint from, input longint to,
                                        input longint step);
    longint mag;
    if (step == 0) return 0;
    mag = ((to >= from) ? to - from : from - to);
    mag = (mag << dlr_pkg::RATIO_BITS) / step;
    return (to >= from) ? mag : -mag;
  endfunction

  // Walk one line and queue every point it emits.
  function automatic void predict_line_points(input stim_row_t cmd);
    longint x0, y0, x1, y1, adx, ady, step, count, incx, incy, posx, posy;
    longint col, rw;
    bit     in_frame;
    pixel_t p;
    x0 = longint'(cmd.sx);
    y0 = longint'(cmd.sy);
    x1 = longint'(cmd.ex);
    y1 = longint'(cmd.ey);
    adx = (x1 >= x0) ? x1 - x0 : x0 - x1;
    ady = (y1 >= y0) ? y1 - y0 : y0 - y1;
    step = (adx >= ady) ? adx : ady;
    count = (step >> FRACTION_BITS) + 1;
    if (count > FRAME_SIZE) count = FRAME_SIZE;
    incx = span_ratio(x0, x1, step) * (longint'(1) << FRACTION_BITS);
    incy = span_ratio(y0, y1, step) * (longint'(1) << FRACTION_BITS);
    posx = x0 << dlr_pkg::RATIO_BITS;
    posy = y0 << dlr_pkg::RATIO_BITS;
    for (longint k = 0; k < count; k++) begin
      in_frame = (posx >= 0) && (posy >= 0);
      col = 0;
      rw  = 0;
      if (in_frame) begin
        col = posx >>> (FRACTION_BITS + dlr_pkg::RATIO_BITS);
        rw  = posy >>> (FRACTION_BITS + dlr_pkg::RATIO_BITS);
        in_frame = (col < longint'(frame_w_model)) && (rw < longint'(frame_h_model));
      end
      p.x     = col[PIX_W-1:0];
      p.y     = rw[PIX_W-1:0];
      p.color = cmd.color;
      p.we    = in_frame;
      p.last  = (k + 1 == count);
      expected_points.push_back(p);
      posx += incx;
      posy += incy;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Row builders
  // ---------------------------------------------------------------------

  function automatic stim_row_t line_row(input logic [COORD_W-1:0] sx, sy, ex, ey,
                                         input logic [31:0] color);
    stim_row_t r;
    r = '0;
    r.kind  = ROW_LINE;
    r.sx    = sx;
    r.sy    = sy;
    r.ex    = ex;
    r.ey    = ey;
    r.color = color;
    return r;
  endfunction

  // Equal endpoints: a single point whose outcome is typed in.
  function automatic stim_row_t point_row(input logic [COORD_W-1:0] x, y,
                                          input logic [31:0] color,
                                          input logic [PIX_W-1:0] px, py,
                                          input logic we);
    stim_row_t r;
    r = line_row(x, y, x, y, color);
    r.typed = 1'b1;
    r.px    = px;
    r.py    = py;
    r.we    = we;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [dlr_pkg::REG_W-1:0] w, h);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.w    = w;
    r.h    = h;
    return r;
  endfunction

  function automatic int clamp_coord(input int v);
    if (v < 0) return 0;
    if (v > (1 << COORD_W) - 1) return (1 << COORD_W) - 1;
    return v;
  endfunction

  // Mostly short lines near a random start; some long, flat, steep or degenerate.
  function automatic stim_row_t random_line();
    int sx, sy, ex, ey;
    sx = $urandom_range(0, (1 << COORD_W) - 1);
    sy = $urandom_range(0, (1 << COORD_W) - 1);
    ex = clamp_coord(sx + $urandom_range(0, 2046) - 1023);
    ey = clamp_coord(sy + $urandom_range(0, 2046) - 1023);
    case ($urandom_range(0, 9))
      0: begin
        ex = sx;
        ey = sy;
      end
      1, 2: begin
        ex = $urandom_range(0, (1 << COORD_W) - 1);
        ey = $urandom_range(0, (1 << COORD_W) - 1);
      end
      3: ey = sy;
      4: ex = sx;
      default: ;
    endcase
    return line_row(sx[COORD_W-1:0], sy[COORD_W-1:0], ex[COORD_W-1:0], ey[COORD_W-1:0],
                    $urandom());
  endfunction

  function automatic logic [dlr_pkg::REG_W-1:0] pick_frame_dim();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 7'd1;
      2: return 7'd64;
      3: return 7'd127;
      default: return 7'($urandom_range(1, 64));
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // Offer one line command after a random gap, or none when tx_quiet; queue its points on the beat.
  task automatic send_line(input stim_row_t cmd);
    int unsigned gap;
    pixel_t      p;
    gap = tx_quiet ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= IN_DW'({cmd.color, cmd.ey, cmd.ex, cmd.sy, cmd.sx});
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    if (cmd.typed) begin
      p.x     = cmd.px;
      p.y     = cmd.py;
      p.color = cmd.color;
      p.we    = cmd.we;
      p.last  = 1'b1;
      expected_points.push_back(p);
    end else begin
      predict_line_points(cmd);
    end
  endtask

  // Drop valid, wait for the last point, then let the block go quiet.
  task automatic settle_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input dlr_pkg::cfg_reg_t idx,
                           input logic [dlr_pkg::REG_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == dlr_pkg::CFG_FRAME_WIDTH) frame_w_model = value;
    else                                 frame_h_model = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_frame(input logic [dlr_pkg::REG_W-1:0] w, h);
    write_reg(dlr_pkg::CFG_FRAME_WIDTH, w);
    write_reg(dlr_pkg::CFG_FRAME_HEIGHT, h);
  endtask

  // Receiver: random ready gaps per point (none when rx_quiet), plus one long hold-off on request.
  initial begin : point_sink
    int unsigned gap;
    m_tready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      gap = rx_quiet ? 0 : $urandom_range(0, 15);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        gap = HOLD_CYCLES;
      end
      @(negedge clk);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Check every point beat against the oldest expectation.
  always @(posedge clk) begin : point_check
    pixel_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected point, tdata", m_tdata, 0);
      end else begin
        want = expected_points.pop_front();
        if (m_tdata[PIX_W-1:0] !== want.x)
          report_mismatch("pixel_x", m_tdata[PIX_W-1:0], want.x);
        if (m_tdata[2*PIX_W-1:PIX_W] !== want.y)
          report_mismatch("pixel_y", m_tdata[2*PIX_W-1:PIX_W], want.y);
        if (m_tdata[OUT_W-1:2*PIX_W] !== want.color)
          report_mismatch("pixel_color", m_tdata[OUT_W-1:2*PIX_W], want.color);
        if (OUT_DW > OUT_W && m_tdata[OUT_DW-1:OUT_W] !== '0)
          report_mismatch("tdata padding", m_tdata[OUT_DW-1:OUT_W], 0);
        if (m_tuser !== want.we)
          report_mismatch("write_enable", m_tuser, want.we);
        if (m_tlast !== want.last)
          report_mismatch("last_point", m_tlast, want.last);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------

  initial begin : main_seq
    rst       = 1'b1;
    s_tdata   = '0;
    s_tvalid  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = dlr_pkg::CFG_FRAME_WIDTH;
    cfg_data  = '0;
    frame_w_model = dlr_pkg::FRAME_RESET;
    frame_h_model = dlr_pkg::FRAME_RESET;

    // Directed table, starting from the reset frame of 64 by 64.
    directed.push_back(point_row(14'h0000, 14'h0000, 32'h0000_0000, 6'd0, 6'd0, 1'b1));
    directed.push_back(point_row(14'h3FFF, 14'h3FFF, 32'hFFFF_FFFF, 6'd63, 6'd63, 1'b1));
    directed.push_back(point_row(14'h00FF, 14'h3F00, 32'hAAAA_AAAA, 6'd0, 6'd63, 1'b1));
    directed.push_back(line_row(14'h0000, 14'h0000, 14'h3FFF, 14'h3FFF, 32'h1234_5678));
    directed.push_back(line_row(14'h3FFF, 14'h0000, 14'h0000, 14'h3FFF, 32'h5555_5555));
    directed.push_back(line_row(14'h0000, 14'h1000, 14'h3FFF, 14'h1000, 32'hA5A5_A5A5));
    directed.push_back(line_row(14'h2000, 14'h3FFF, 14'h2000, 14'h0000, 32'h0F0F_0F0F));
    directed.push_back(line_row(14'h0180, 14'h0280, 14'h01FF, 14'h0290, 32'hDEAD_BEEF));
    directed.push_back(line_row(14'h0100, 14'h0100, 14'h0200, 14'h0180, 32'h0000_0001));
    directed.push_back(line_row(14'h1234, 14'h0F0F, 14'h0ABC, 14'h2E2E, 32'h8000_0000));
    // Column equal to the width and row equal to the height are clipped.
    directed.push_back(cfg_row(7'd5, 7'd3));
    directed.push_back(point_row(14'h0500, 14'h0000, 32'hCAFE_0001, 6'd5, 6'd0, 1'b0));
    directed.push_back(point_row(14'h04FF, 14'h02FF, 32'hCAFE_0002, 6'd4, 6'd2, 1'b1));
    directed.push_back(point_row(14'h0000, 14'h0300, 32'hCAFE_0003, 6'd0, 6'd3, 1'b0));
    directed.push_back(line_row(14'h0000, 14'h0000, 14'h0A00, 14'h0800, 32'hCAFE_0004));
    // Zero frame: nothing is written.
    directed.push_back(cfg_row(7'd0, 7'd0));
    directed.push_back(point_row(14'h0000, 14'h0000, 32'h0BAD_0000, 6'd0, 6'd0, 1'b0));
    directed.push_back(line_row(14'h0100, 14'h0200, 14'h3000, 14'h0400, 32'h0BAD_0001));
    // Frame above the coordinate range: everything fits.
    directed.push_back(cfg_row(7'd127, 7'd127));
    directed.push_back(point_row(14'h3FFF, 14'h3FFF, 32'h7F7F_7F7F, 6'd63, 6'd63, 1'b1));
    directed.push_back(line_row(14'h3FFF, 14'h3FFF, 14'h0000, 14'h0000, 32'h7F7F_0000));
    // One-pixel frame.
    directed.push_back(cfg_row(7'd1, 7'd1));
    directed.push_back(point_row(14'h00FF, 14'h00FF, 32'h0101_0101, 6'd0, 6'd0, 1'b1));
    directed.push_back(point_row(14'h0100, 14'h0000, 32'h0101_0102, 6'd1, 6'd0, 1'b0));
    directed.push_back(line_row(14'h0000, 14'h0000, 14'h0300, 14'h0300, 32'h0101_0103));
    directed.push_back(cfg_row(7'd64, 7'd64));
    directed.push_back(line_row(14'h3E00, 14'h0010, 14'h3FFF, 14'h3FF0, 32'h6464_6464));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        settle_idle();
        write_frame(directed[i].w, directed[i].h);
      end else begin
        send_line(directed[i]);
      end
    end

    // Random phases: change the frame between phases, vary the idling style.
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle_idle();
      if (p == 0) write_frame(7'd64, 7'd64);
      else        write_frame(pick_frame_dim(), pick_frame_dim());
      tx_quiet    = (p == 2);
      rx_quiet    = (p == 3);
      rx_hold_req = (p == 1);
      for (int n = 0; n < PHASE_LINES; n++) send_line(random_line());
    end

    settle_idle();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
